>>> sv/assert_macros.svh
// Assertion helpers used by the RTL. Clock and reset names follow the
// project convention (clk_i, rst_ni).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CHK(lbl, !(cond), msg)

`endif

>>> sv/ocsc_pkg.sv
`default_nettype none

package ocsc_pkg;

  // Default structural parameters
  localparam int ADC_BITS_DEF       = 12;
  localparam int MAX_BURST_LOG2_DEF = 16;

  // Fixed field widths
  localparam int CUR_W      = 22;
  localparam int GAIN_W     = 24;
  localparam int ICPT_W     = 19;
  localparam int DB_W       = 17;
  localparam int LG_CFG_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Scaling and limits
  localparam int Q_SHIFT   = 16;
  localparam int CUR_LIMIT = 1200000;

  // Register reset values
  localparam logic [GAIN_W-1:0]   GAIN_RST    = GAIN_W'(1964402);
  localparam logic [ICPT_W-1:0]   ICPT_RST    = '0;
  localparam logic [DB_W-1:0]     DB_RST      = DB_W'(200);
  localparam logic [LG_CFG_W-1:0] ZERO_LG_RST = LG_CFG_W'(8);
  localparam logic [LG_CFG_W-1:0] READ_LG_RST = LG_CFG_W'(12);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 3'd0,
    CFG_INTERCEPT = 3'd1,
    CFG_DEADBAND  = 3'd2,
    CFG_ZERO_LG   = 3'd3,
    CFG_READ_LG   = 3'd4
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> sv/ocsc_accum.sv
`default_nettype none

// Burst accumulator: sums codes over a power-of-two burst and hands the
// finished sum to the next stage through a one-entry burst register.
module ocsc_accum #(
  parameter int ADC_BITS       = ocsc_pkg::ADC_BITS_DEF,
  parameter int MAX_BURST_LOG2 = ocsc_pkg::MAX_BURST_LOG2_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // sample input
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [ADC_BITS-1:0]                    code_i,
  input  wire logic                                   ok_i,
  // burst lengths from config
  input  wire logic [ocsc_pkg::LG_CFG_W-1:0]          zero_lg_i,
  input  wire logic [ocsc_pkg::LG_CFG_W-1:0]          read_lg_i,
  // finished burst
  output logic                                        burst_valid_o,
  input  wire logic                                   burst_ready_i,
  output logic [ADC_BITS+MAX_BURST_LOG2-1:0]          burst_sum_o,
  output logic [$clog2(MAX_BURST_LOG2+1)-1:0]         burst_lg_o,
  output logic                                        burst_zero_o,
  // baseline burst done
  output logic                                        zeroed_o
);
  import ocsc_pkg::*;

  localparam int ACC_W = ADC_BITS + MAX_BURST_LOG2;
  localparam int CNT_W = MAX_BURST_LOG2 + 1;
  localparam int LG_W  = $clog2(MAX_BURST_LOG2 + 1);

  logic [ACC_W-1:0]    acc_q, acc_add;
  logic [CNT_W-1:0]    cnt_q, cnt_inc, target;
  logic                zeroed_q;
  logic [LG_CFG_W-1:0] lg_sel;
  logic [LG_W-1:0]     lg;
  logic                burst_end, in_fire;
  logic                b_v_q, b_zero_q;
  logic [ACC_W-1:0]    b_sum_q;
  logic [LG_W-1:0]     b_lg_q;

  // Active burst length, clamped to 1..MAX
  always_comb begin
    lg_sel = zeroed_q ? read_lg_i : zero_lg_i;
    if (lg_sel == '0) begin
      lg = LG_W'(1);
    end else if (lg_sel > LG_CFG_W'(MAX_BURST_LOG2)) begin
      lg = LG_W'(MAX_BURST_LOG2);
    end else begin
      lg = lg_sel[LG_W-1:0];
    end
  end

  // End of burst depends on count and burst length only, never on the beat's data
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign target    = CNT_W'(1) << lg;
  assign burst_end = (cnt_inc >= target);
  assign acc_add   = acc_q + (ok_i ? ACC_W'(code_i) : '0);

  assign in_ready_o = !burst_end || !b_v_q || burst_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Accumulator, counter and baseline flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      zeroed_q <= 1'b0;
    end else if (in_fire) begin
      if (burst_end) begin
        acc_q    <= '0;
        cnt_q    <= '0;
        zeroed_q <= 1'b1;
      end else begin
        acc_q <= acc_add;
        cnt_q <= cnt_inc;
      end
    end
  end

  // Burst register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (in_fire && burst_end) begin
      b_v_q <= 1'b1;
    end else if (burst_ready_i) begin
      b_v_q <= 1'b0;
    end
  end

  // Burst register payload
  always_ff @(posedge clk_i) begin
    if (in_fire && burst_end) begin
      b_sum_q  <= acc_add;
      b_lg_q   <= lg;
      b_zero_q <= !zeroed_q;
    end
  end

  assign burst_valid_o = b_v_q;
  assign burst_sum_o   = b_sum_q;
  assign burst_lg_o    = b_lg_q;
  assign burst_zero_o  = b_zero_q;
  assign zeroed_o      = zeroed_q;

endmodule

`default_nettype wire

>>> sv/ocsc_scale.sv
`default_nettype none

// Gain, intercept, saturation and deadband, in a multiply stage and a
// result stage; the result stage is the output register.
module ocsc_scale #(
  parameter int ADC_BITS = ocsc_pkg::ADC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // offset-corrected mean
  input  wire logic                               d_valid_i,
  output logic                                    d_ready_o,
  input  wire logic signed [ADC_BITS:0]           diff_i,
  input  wire logic [ADC_BITS-1:0]                mean_i,
  // calibration registers
  input  wire logic [ocsc_pkg::GAIN_W-1:0]        gain_i,
  input  wire logic signed [ocsc_pkg::ICPT_W-1:0] icpt_i,
  input  wire logic [ocsc_pkg::DB_W-1:0]          db_i,
  // result
  output logic                                    r_valid_o,
  input  wire logic                               r_ready_i,
  output logic signed [ocsc_pkg::CUR_W-1:0]       r_cur_o,
  output logic [ADC_BITS-1:0]                     r_mean_o
);
  import ocsc_pkg::*;

  localparam int DIFF_W = ADC_BITS + 1;
  localparam int PROD_W = DIFF_W + GAIN_W;
  localparam int SHF_W  = PROD_W - Q_SHIFT;
  localparam int SUM_W  = ((SHF_W > CUR_W) ? SHF_W : CUR_W) + 1;

  logic                     p_v_q, p_ready;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [ADC_BITS-1:0]      p_mean_q;
  logic                     o_v_q, o_ready;
  logic signed [CUR_W-1:0]  cur_q;
  logic [ADC_BITS-1:0]      o_mean_q;
  logic signed [SUM_W-1:0]  shf, sum, sat, dbs;
  logic signed [CUR_W-1:0]  cur_d;

  assign o_ready   = !o_v_q || r_ready_i;
  assign p_ready   = !p_v_q || o_ready;
  assign d_ready_o = p_ready;

  // Multiply stage
  assign prod_d = PROD_W'(diff_i) * PROD_W'(signed'({1'b0, gain_i}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (p_ready) begin
      p_v_q <= d_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && d_valid_i) begin
      prod_q   <= prod_d;
      p_mean_q <= mean_i;
    end
  end

  // Floor shift, intercept, clamp, deadband
  always_comb begin
    shf = signed'(SUM_W'(prod_q >>> Q_SHIFT));
    sum = shf + SUM_W'(icpt_i);
    dbs = signed'(SUM_W'({1'b0, db_i}));
    if (sum > SUM_W'(CUR_LIMIT)) begin
      sat = SUM_W'(CUR_LIMIT);
    end else if (sum < -SUM_W'(CUR_LIMIT)) begin
      sat = -SUM_W'(CUR_LIMIT);
    end else begin
      sat = sum;
    end
    if (sat > -dbs && sat < dbs) begin
      cur_d = '0;
    end else begin
      cur_d = sat[CUR_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_ready) begin
      o_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && p_v_q) begin
      cur_q    <= cur_d;
      o_mean_q <= p_mean_q;
    end
  end

  assign r_valid_o = o_v_q;
  assign r_cur_o   = cur_q;
  assign r_mean_o  = o_mean_q;

endmodule

`default_nettype wire

>>> sv/oversampled_current_sense_calibrator_core.sv
// Four register stages with valid/ready each: burst, difference, multiply, output.
// Throughput: one sample beat per cycle while s_axis_tready is high; one result per
// measurement burst on m_axis, none for the first (baseline) burst.
// Reset: counters, accumulator, baseline flag and valids clear; calibration
// registers take their defaults; the baseline code is written by the first burst.
`default_nettype none

module oversampled_current_sense_calibrator_core #(
  parameter int ADC_BITS       = ocsc_pkg::ADC_BITS_DEF,
  parameter int MAX_BURST_LOG2 = ocsc_pkg::MAX_BURST_LOG2_DEF
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  // sample stream
  input  wire logic                                          s_axis_tvalid,
  output logic                                               s_axis_tready,
  input  wire logic [((ADC_BITS+7)/8)*8-1:0]                 s_axis_tdata,  // sample
  input  wire logic                                          s_axis_tuser,  // sample_ok
  // result stream
  output logic                                               m_axis_tvalid,
  input  wire logic                                          m_axis_tready,
  output logic [((ocsc_pkg::CUR_W+ADC_BITS+7)/8)*8-1:0]      m_axis_tdata,  // current_ma, burst_mean
  // configuration writes
  input  wire logic                                          cfg_we_i,
  input  wire logic [ocsc_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  wire logic [ocsc_pkg::CFG_DATA_W-1:0]               cfg_data_i
);
  import ocsc_pkg::*;

  `include "assert_macros.svh"

  localparam int ACC_W      = ADC_BITS + MAX_BURST_LOG2;
  localparam int LG_W       = $clog2(MAX_BURST_LOG2 + 1);
  localparam int M_TDATA_W  = ((CUR_W + ADC_BITS + 7) / 8) * 8;
  localparam int CODE_MAX   = (1 << ADC_BITS) - 1;

  // Calibration registers
  logic [GAIN_W-1:0]        gain_q;
  logic signed [ICPT_W-1:0] icpt_q;
  logic [DB_W-1:0]          db_q;
  logic [LG_CFG_W-1:0]      zero_lg_q, read_lg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GAIN_RST;
      icpt_q    <= ICPT_RST;
      db_q      <= DB_RST;
      zero_lg_q <= ZERO_LG_RST;
      read_lg_q <= READ_LG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN:      gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_INTERCEPT: icpt_q    <= cfg_data_i[ICPT_W-1:0];
        CFG_DEADBAND:  db_q      <= cfg_data_i[DB_W-1:0];
        CFG_ZERO_LG:   zero_lg_q <= cfg_data_i[LG_CFG_W-1:0];
        CFG_READ_LG:   read_lg_q <= cfg_data_i[LG_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Burst accumulation
  logic              b_valid, b_ready, b_zero, zeroed;
  logic [ACC_W-1:0]  b_sum;
  logic [LG_W-1:0]   b_lg;

  ocsc_accum #(
    .ADC_BITS       (ADC_BITS),
    .MAX_BURST_LOG2 (MAX_BURST_LOG2)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .code_i        (s_axis_tdata[ADC_BITS-1:0]),
    .ok_i          (s_axis_tuser),
    .zero_lg_i     (zero_lg_q),
    .read_lg_i     (read_lg_q),
    .burst_valid_o (b_valid),
    .burst_ready_i (b_ready),
    .burst_sum_o   (b_sum),
    .burst_lg_o    (b_lg),
    .burst_zero_o  (b_zero),
    .zeroed_o      (zeroed)
  );

  // Mean and baseline subtraction
  logic [ACC_W-1:0]           mean_full;
  logic [ADC_BITS-1:0]        mean, baseline_q, mean_q;
  logic signed [ADC_BITS:0]   diff_q;
  logic                       d_v_q, d_ready;

  assign mean_full = b_sum >> b_lg;
  assign mean      = (mean_full > ACC_W'(CODE_MAX)) ? ADC_BITS'(CODE_MAX)
                                                    : mean_full[ADC_BITS-1:0];
  assign b_ready   = !d_v_q || d_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (b_ready) begin
      d_v_q <= b_valid && !b_zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid && b_ready) begin
      if (b_zero) begin
        baseline_q <= mean;
      end else begin
        diff_q <= signed'({1'b0, mean}) - signed'({1'b0, baseline_q});
        mean_q <= mean;
      end
    end
  end

  // Scaling and output
  logic                     r_valid;
  logic signed [CUR_W-1:0]  r_cur;
  logic [ADC_BITS-1:0]      r_mean;

  ocsc_scale #(
    .ADC_BITS (ADC_BITS)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .d_valid_i (d_v_q),
    .d_ready_o (d_ready),
    .diff_i    (diff_q),
    .mean_i    (mean_q),
    .gain_i    (gain_q),
    .icpt_i    (icpt_q),
    .db_i      (db_q),
    .r_valid_o (r_valid),
    .r_ready_i (m_axis_tready),
    .r_cur_o   (r_cur),
    .r_mean_o  (r_mean)
  );

  assign m_axis_tvalid = r_valid;
  assign m_axis_tdata  = M_TDATA_W'({r_mean, r_cur});

  // A measurement only exists once the baseline burst has finished
  `ASSERT_CHK(a_diff_after_zero, d_v_q |-> zeroed, "measurement before baseline")

  // A baseline burst never enters the scaling path
  `ASSERT_CHK(a_zero_no_result,
    (b_valid && b_ready && b_zero) |=> !d_v_q, "baseline burst produced a result")

  // Results respect the clamp and the deadband
  `ASSERT_NEVER(a_result_range,
    m_axis_tvalid && (r_cur > CUR_W'(CUR_LIMIT) || r_cur < -CUR_W'(CUR_LIMIT) ||
    (r_cur != '0 && r_cur > -signed'(CUR_W'(db_q)) && r_cur < signed'(CUR_W'(db_q)))),
    "result outside clamp or inside deadband")

endmodule

`default_nettype wire
